>>> hdl/wia_pkg.sv
// shared constants, types and codes for the wide integer alu
`timescale 1ns / 1ps
package wia_pkg;

    localparam int WORDS  = 8;
    localparam int WORD_W = 32;
    localparam int N_BITS = WORDS * WORD_W;
    localparam int IDX_W  = $clog2(WORDS);
    localparam int COL_W  = $clog2(WORDS + 1);
    localparam int BIT_W  = $clog2(N_BITS);
    localparam int AMT_W  = 10;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORDS-1:0][WORD_W-1:0] word_vec_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_EXEC   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_XOR  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SHR  = 4'd9,
        OP_CMP  = 4'd10,
        OP_INC  = 4'd11,
        OP_DEC  = 4'd12,
        OP_NOT  = 4'd13,
        OP_ZERO = 4'd14,
        OP_POW  = 4'd15
    } op_t;

    localparam logic [1:0] CMP_LESS    = 2'd0;
    localparam logic [1:0] CMP_EQUAL   = 2'd1;
    localparam logic [1:0] CMP_GREATER = 2'd2;

    typedef struct packed {
        logic [1:0] cmp;
        logic       is_zero;
        logic       div_zero;
    } core_status_t;

endpackage

>>> hdl/wia_mul.sv
// word-serial truncated multiplier, one 32x32 product per cycle while busy
`timescale 1ns / 1ps
module wia_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  wia_pkg::word_vec_t x_in,
    input  wia_pkg::word_vec_t y_in,
    output logic              done,
    output wia_pkg::word_vec_t prod
);

    logic                      busy_reg;
    logic                      done_reg;
    wia_pkg::word_vec_t        x_reg;
    wia_pkg::word_vec_t        y_reg;
    wia_pkg::word_vec_t        p_reg;
    wia_pkg::word_vec_t        r_reg;
    logic [wia_pkg::COL_W-1:0] col_reg;
    logic [wia_pkg::IDX_W-1:0] row_reg;
    wia_pkg::word_t            carry_reg;

    logic           col_end;
    logic           row_end;
    wia_pkg::word_t yw;
    logic [63:0]    t;
    wia_pkg::word_t push;

    always_comb begin
        col_end = (col_reg == wia_pkg::COL_W'(wia_pkg::WORDS));
        row_end = (row_reg == wia_pkg::IDX_W'(wia_pkg::WORDS - 1));
        yw      = col_end ? '0 : y_reg[0];
        t       = ({32'd0, x_reg[0]} * {32'd0, yw}) + {32'd0, p_reg[0]}
                  + {32'd0, carry_reg};
        if (col_end) begin
            push = carry_reg;
        end else if (col_reg == '0) begin
            push = '0;
        end else begin
            push = t[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && col_end && row_end;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && col_end && row_end) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg     <= x_in;
            y_reg     <= y_in;
            p_reg     <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            carry_reg <= '0;
        end else if (busy_reg) begin
            p_reg <= {push, p_reg[wia_pkg::WORDS-1:1]};
            if (col_reg == '0) begin
                r_reg <= {t[31:0], r_reg[wia_pkg::WORDS-1:1]};
            end
            if (!col_end) begin
                y_reg     <= {y_reg[0], y_reg[wia_pkg::WORDS-1:1]};
                carry_reg <= t[63:32];
                col_reg   <= col_reg + 1'b1;
            end else begin
                x_reg     <= {x_reg[0], x_reg[wia_pkg::WORDS-1:1]};
                carry_reg <= '0;
                col_reg   <= '0;
                row_reg   <= row_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign prod = r_reg;

endmodule

>>> hdl/wia_core.sv
// operation sequencer: compare pass, word-serial alu, shifter, divider, multiplier, pow
`timescale 1ns / 1ps
module wia_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  wia_pkg::op_t              op,
    input  logic [wia_pkg::AMT_W-1:0] amount,
    input  wia_pkg::word_vec_t        a,
    input  wia_pkg::word_vec_t        b,
    output logic                      done,
    output wia_pkg::word_vec_t        result,
    output wia_pkg::core_status_t     status
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CMP       = 13'b0000000000010,
        S_ALU       = 13'b0000000000100,
        S_CONST     = 13'b0000000001000,
        S_SHIFT     = 13'b0000000010000,
        S_DIV_SHIFT = 13'b0000000100000,
        S_DIV_SUB   = 13'b0000001000000,
        S_DIV_END   = 13'b0000010000000,
        S_MUL       = 13'b0000100000000,
        S_POW       = 13'b0001000000000,
        S_POW_M1    = 13'b0010000000000,
        S_POW_M2    = 13'b0100000000000,
        S_FINISH    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    wia_pkg::word_vec_t        x_reg, x_next;
    wia_pkg::word_vec_t        y_reg, y_next;
    wia_pkg::word_vec_t        t_reg, t_next;
    wia_pkg::word_vec_t        q_reg, q_next;
    wia_pkg::word_vec_t        d_reg, d_next;
    wia_pkg::word_vec_t        r_reg, r_next;
    wia_pkg::word_vec_t        e_reg, e_next;
    wia_pkg::op_t              op_reg, op_next;
    logic [wia_pkg::AMT_W-1:0] amt_reg, amt_next;
    logic [wia_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic [wia_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic                      carry_reg, carry_next;
    logic                      out_reg, out_next;
    logic [1:0]                cmp_reg, cmp_next;
    logic                      az_reg, az_next;
    logic                      bz_reg, bz_next;
    logic                      dz_reg, dz_next;

    logic               mul_start;
    wia_pkg::word_vec_t mul_x;
    wia_pkg::word_vec_t mul_y;
    logic               mul_done;
    wia_pkg::word_vec_t mul_prod;

    wia_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x_in    (mul_x),
        .y_in    (mul_y),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    wia_pkg::word_t xw, yw, yv, alu_word;
    logic [32:0]    sum, diff, dsub;
    logic           last;
    logic [1:0]     cmp_step;
    logic           az_step, bz_step;

    always_comb begin
        xw   = x_reg[0];
        yw   = y_reg[0];
        last = (cnt_reg == wia_pkg::IDX_W'(wia_pkg::WORDS - 1));
        if (xw > yw) begin
            cmp_step = wia_pkg::CMP_GREATER;
        end else if (xw < yw) begin
            cmp_step = wia_pkg::CMP_LESS;
        end else begin
            cmp_step = cmp_reg;
        end
        az_step = az_reg && (xw == '0);
        bz_step = bz_reg && (yw == '0);
        if (op_reg == wia_pkg::OP_INC || op_reg == wia_pkg::OP_DEC) begin
            yv = (cnt_reg == '0) ? wia_pkg::word_t'(1) : '0;
        end else begin
            yv = yw;
        end
        sum  = {1'b0, xw} + {1'b0, yv} + {32'd0, carry_reg};
        diff = {1'b0, xw} - {1'b0, yv} - {32'd0, carry_reg};
        dsub = {1'b0, t_reg[0]} - {1'b0, yw} - {32'd0, carry_reg};
        case (op_reg)
            wia_pkg::OP_ADD, wia_pkg::OP_INC: alu_word = sum[31:0];
            wia_pkg::OP_SUB, wia_pkg::OP_DEC: alu_word = diff[31:0];
            wia_pkg::OP_AND: alu_word = xw & yw;
            wia_pkg::OP_OR:  alu_word = xw | yw;
            wia_pkg::OP_XOR: alu_word = xw ^ yw;
            default:         alu_word = ~xw;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        op_next    = op_reg;
        amt_next   = amt_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        carry_next = carry_reg;
        out_next   = out_reg;
        cmp_next   = cmp_reg;
        az_next    = az_reg;
        bz_next    = bz_reg;
        dz_next    = dz_reg;
        mul_start  = 1'b0;
        mul_x      = t_reg;
        mul_y      = q_reg;
        done       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    x_next     = a;
                    y_next     = b;
                    op_next    = op;
                    amt_next   = amount;
                    cnt_next   = '0;
                    cmp_next   = wia_pkg::CMP_EQUAL;
                    az_next    = 1'b1;
                    bz_next    = 1'b1;
                    dz_next    = 1'b0;
                    carry_next = 1'b0;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmp_next = cmp_step;
                az_next  = az_step;
                bz_next  = bz_step;
                x_next   = {x_reg[0], x_reg[wia_pkg::WORDS-1:1]};
                y_next   = {y_reg[0], y_reg[wia_pkg::WORDS-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last) begin
                    cnt_next = '0;
                    case (op_reg)
                        wia_pkg::OP_CMP, wia_pkg::OP_ZERO: begin
                            state_next = S_CONST;
                        end
                        wia_pkg::OP_SHL, wia_pkg::OP_SHR: begin
                            if ({1'b0, amt_reg} >= (wia_pkg::AMT_W + 1)'(wia_pkg::N_BITS)) begin
                                r_next     = '0;
                                state_next = S_FINISH;
                            end else begin
                                state_next = S_SHIFT;
                            end
                        end
                        wia_pkg::OP_MUL: begin
                            mul_start  = 1'b1;
                            mul_x      = a;
                            mul_y      = b;
                            state_next = S_MUL;
                        end
                        wia_pkg::OP_DIV, wia_pkg::OP_MOD: begin
                            if (bz_step) begin
                                r_next     = '0;
                                dz_next    = 1'b1;
                                state_next = S_FINISH;
                            end else begin
                                t_next     = '0;
                                q_next     = '0;
                                bit_next   = '0;
                                state_next = S_DIV_SHIFT;
                            end
                        end
                        wia_pkg::OP_POW: begin
                            t_next     = wia_pkg::word_vec_t'(1);
                            q_next     = a;
                            e_next     = b;
                            state_next = S_POW;
                        end
                        default: begin
                            state_next = S_ALU;
                        end
                    endcase
                end
            end
            S_ALU: begin
                r_next   = {alu_word, r_reg[wia_pkg::WORDS-1:1]};
                x_next   = {x_reg[0], x_reg[wia_pkg::WORDS-1:1]};
                y_next   = {y_reg[0], y_reg[wia_pkg::WORDS-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == wia_pkg::OP_SUB || op_reg == wia_pkg::OP_DEC) begin
                    carry_next = diff[32];
                end else begin
                    carry_next = sum[32];
                end
                if (last) begin
                    cnt_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_CONST: begin
                r_next = '0;
                if (op_reg == wia_pkg::OP_CMP) begin
                    r_next[0] = wia_pkg::word_t'(cmp_reg);
                end else begin
                    r_next[0] = wia_pkg::word_t'(az_reg);
                end
                state_next = S_FINISH;
            end
            S_SHIFT: begin
                if (amt_reg >= wia_pkg::AMT_W'(wia_pkg::WORD_W)) begin
                    x_next   = (op_reg == wia_pkg::OP_SHL) ? (x_reg << wia_pkg::WORD_W)
                                                           : (x_reg >> wia_pkg::WORD_W);
                    amt_next = amt_reg - wia_pkg::AMT_W'(wia_pkg::WORD_W);
                end else if (amt_reg != '0) begin
                    x_next   = (op_reg == wia_pkg::OP_SHL) ? (x_reg << 1) : (x_reg >> 1);
                    amt_next = amt_reg - 1'b1;
                end else begin
                    r_next     = x_reg;
                    state_next = S_FINISH;
                end
            end
            S_DIV_SHIFT: begin
                out_next   = t_reg[wia_pkg::WORDS-1][wia_pkg::WORD_W-1];
                t_next     = (t_reg << 1)
                             | wia_pkg::word_vec_t'(x_reg[wia_pkg::WORDS-1][wia_pkg::WORD_W-1]);
                x_next     = x_reg << 1;
                carry_next = 1'b0;
                cnt_next   = '0;
                state_next = S_DIV_SUB;
            end
            S_DIV_SUB: begin
                d_next     = {dsub[31:0], d_reg[wia_pkg::WORDS-1:1]};
                t_next     = {t_reg[0], t_reg[wia_pkg::WORDS-1:1]};
                y_next     = {y_reg[0], y_reg[wia_pkg::WORDS-1:1]};
                carry_next = dsub[32];
                cnt_next   = cnt_reg + 1'b1;
                if (last) begin
                    cnt_next   = '0;
                    carry_next = 1'b0;
                    if (out_reg || !dsub[32]) begin
                        t_next = {dsub[31:0], d_reg[wia_pkg::WORDS-1:1]};
                        q_next = (q_reg << 1) | wia_pkg::word_vec_t'(1);
                    end else begin
                        q_next = q_reg << 1;
                    end
                    bit_next = bit_reg + 1'b1;
                    if (bit_reg == wia_pkg::BIT_W'(wia_pkg::N_BITS - 1)) begin
                        state_next = S_DIV_END;
                    end else begin
                        state_next = S_DIV_SHIFT;
                    end
                end
            end
            S_DIV_END: begin
                r_next     = (op_reg == wia_pkg::OP_DIV) ? q_reg : t_reg;
                state_next = S_FINISH;
            end
            S_MUL: begin
                if (mul_done) begin
                    r_next     = mul_prod;
                    state_next = S_FINISH;
                end
            end
            S_POW: begin
                if (e_reg == '0) begin
                    r_next     = t_reg;
                    state_next = S_FINISH;
                end else if (e_reg[0][0]) begin
                    mul_start  = 1'b1;
                    state_next = S_POW_M1;
                end else begin
                    mul_start  = 1'b1;
                    mul_x      = q_reg;
                    state_next = S_POW_M2;
                end
            end
            S_POW_M1: begin
                if (mul_done) begin
                    t_next     = mul_prod;
                    mul_start  = 1'b1;
                    mul_x      = q_reg;
                    state_next = S_POW_M2;
                end
            end
            S_POW_M2: begin
                if (mul_done) begin
                    q_next     = mul_prod;
                    e_next     = e_reg >> 1;
                    state_next = S_POW;
                end
            end
            S_FINISH: begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        t_reg     <= t_next;
        q_reg     <= q_next;
        d_reg     <= d_next;
        r_reg     <= r_next;
        e_reg     <= e_next;
        op_reg    <= op_next;
        amt_reg   <= amt_next;
        cnt_reg   <= cnt_next;
        bit_reg   <= bit_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
        cmp_reg   <= cmp_next;
        az_reg    <= az_next;
        bz_reg    <= bz_next;
        dz_reg    <= dz_next;
    end

    assign result          = r_reg;
    assign status.cmp      = cmp_reg;
    assign status.is_zero  = (op_reg == wia_pkg::OP_ZERO) ? az_reg : (r_reg == '0);
    assign status.div_zero = dz_reg;

endmodule

>>> hdl/wide_integer_alu.sv
// top level: operand stores, execute control and result word output
// loads write one operand word; an execute item: compare pass, operation, finish state
// operation: add/sub/logic/inc/dec/not word-serial, cmp/zero constant, shifts words then bits,
// mul word-serial, div/mod restoring one quotient bit per pass, pow up to 64*WORDS multiplies
// results then leave one word per cycle with m_ready high; next item taken after the last word
// synchronous active-low reset clears both operand stores to zero
`timescale 1ns / 1ps
module wide_integer_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [4:0]  s_word_index,
    input  logic [31:0] s_word_value,
    input  logic [3:0]  s_opcode,
    input  logic [9:0]  s_shift_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_word,
    output logic [4:0]  m_result_index,
    output logic        m_last_word,
    output logic [1:0]  m_compare_result,
    output logic        m_result_is_zero,
    output logic        m_divide_by_zero
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_RUN  = 3'b010,
        T_OUT  = 3'b100
    } top_state_t;

    top_state_t state_reg;

    wia_pkg::word_vec_t        a_reg;
    wia_pkg::word_vec_t        b_reg;
    wia_pkg::word_vec_t        o_reg;
    logic [wia_pkg::IDX_W-1:0] idx_reg;
    wia_pkg::core_status_t     st_reg;

    logic                  s_fire;
    logic                  idx_ok;
    logic                  core_start;
    logic                  core_done;
    wia_pkg::word_vec_t    core_result;
    wia_pkg::core_status_t core_status;
    logic                  out_last;

    assign s_ready    = (state_reg == T_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign idx_ok     = ({1'b0, s_word_index} < 6'(wia_pkg::WORDS));
    assign core_start = s_fire && (wia_pkg::cmd_t'(s_cmd) == wia_pkg::CMD_EXEC);
    assign out_last   = (idx_reg == wia_pkg::IDX_W'(wia_pkg::WORDS - 1));

    wia_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .op      (wia_pkg::op_t'(s_opcode)),
        .amount  (s_shift_amount),
        .a       (a_reg),
        .b       (b_reg),
        .done    (core_done),
        .result  (core_result),
        .status  (core_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
        end else begin
            case (state_reg)
                T_IDLE: begin
                    if (s_fire && idx_ok) begin
                        if (wia_pkg::cmd_t'(s_cmd) == wia_pkg::CMD_LOAD_A) begin
                            a_reg[s_word_index[wia_pkg::IDX_W-1:0]] <= s_word_value;
                        end else if (wia_pkg::cmd_t'(s_cmd) == wia_pkg::CMD_LOAD_B) begin
                            b_reg[s_word_index[wia_pkg::IDX_W-1:0]] <= s_word_value;
                        end
                    end
                    if (core_start) begin
                        state_reg <= T_RUN;
                    end
                end
                T_RUN: begin
                    if (core_done) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_ready && out_last) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == T_RUN && core_done) begin
            o_reg   <= core_result;
            st_reg  <= core_status;
            idx_reg <= '0;
        end else if (state_reg == T_OUT && m_ready) begin
            o_reg   <= o_reg >> wia_pkg::WORD_W;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign m_valid          = (state_reg == T_OUT);
    assign m_result_word    = o_reg[0];
    assign m_result_index   = 5'(idx_reg);
    assign m_last_word      = out_last;
    assign m_compare_result = st_reg.cmp;
    assign m_result_is_zero = st_reg.is_zero;
    assign m_divide_by_zero = st_reg.div_zero;

`ifndef SYNTHESIS
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> state_reg == T_RUN)
        else $error("core finished outside of a run");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> s_ready)
        else $error("block not free after last result word");
`endif

endmodule
